// ----- rtl/core/sse_event_stream_tokenizer_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the SSE tokenizer.
// Each macro expects clk and rst to be in scope.
// ---------------------------------------------------------------------------
`ifndef SSE_EVENT_STREAM_TOKENIZER_DEFINES_SVH
`define SSE_EVENT_STREAM_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define SSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sse_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_pkg
// Types and constants shared by the SSE tokenizer modules.
// ---------------------------------------------------------------------------
package sse_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_NAME   = 3'd1,
    MODE_VFIRST = 3'd2,
    MODE_VALUE  = 3'd3,
    MODE_SKIP   = 3'd4
  } line_mode_t;

  localparam logic [1:0] TOK_BEGIN    = 2'd0;
  localparam logic [1:0] TOK_BYTE     = 2'd1;
  localparam logic [1:0] TOK_DISPATCH = 2'd2;
  localparam logic [1:0] TOK_CLEAR    = 2'd3;

  localparam logic [1:0] FIELD_EVENT = 2'd0;
  localparam logic [1:0] FIELD_DATA  = 2'd1;
  localparam logic [1:0] FIELD_ID    = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0]  NAME_MAX_LEN = 3'd5;
  localparam logic [2:0]  LEN_EVENT    = 3'd5;
  localparam logic [2:0]  LEN_DATA     = 3'd4;
  localparam logic [2:0]  LEN_ID       = 3'd2;
  localparam logic [39:0] PACK_EVENT   = 40'h65_7665_6E74;
  localparam logic [39:0] PACK_DATA    = 40'h00_6461_7461;
  localparam logic [39:0] PACK_ID      = 40'h00_0000_6964;

  typedef struct packed {
    logic [1:0] token;
    logic [1:0] field_tag;
    logic [7:0] char_out;
    logic       append_newline;
    logic       type_given;
  } result_t;

  // one request worth of results: r0 always valid, r1 when two is set
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

// ----- rtl/core/sse_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_in_if
// Input channel: stream byte or restart request.
// ---------------------------------------------------------------------------
interface sse_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, kind, char_in, input ready);
  modport sink (input valid, kind, char_in, output ready);
endinterface

// ----- rtl/core/sse_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_out_if
// Output channel: one token per transfer.
// ---------------------------------------------------------------------------
interface sse_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token;
  logic [1:0] field_tag;
  logic [7:0] char_out;
  logic       append_newline;
  logic       type_given;
  logic       last_of_run;

  modport source (output valid, token, field_tag, char_out, append_newline,
                  type_given, last_of_run, input ready);
  modport sink (input valid, token, field_tag, char_out, append_newline,
                type_given, last_of_run, output ready);
endinterface

// ----- rtl/core/sse_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_front
// Line parser: takes one request per cycle while the queue is not full, updates
// the line state and produces the zero, one or two tokens that the request causes.
// ---------------------------------------------------------------------------
module sse_front (
  input  logic             clk,
  input  logic             rst,
  sse_in_if.sink           ingress,
  input  logic             full,
  output logic             push,
  output sse_pkg::entry_t  push_entry
);

  typedef struct packed {
    logic [39:0] chars;
    logic [2:0]  len;
    logic        too_long;
  } name_t;

  typedef struct packed {
    logic [1:0]       cnt;
    sse_pkg::result_t r0;
    sse_pkg::result_t r1;
  } res_pair_t;

  function automatic name_t push_name(name_t n, logic [7:0] ch);
    name_t r;
    r = n;
    if (n.len < sse_pkg::NAME_MAX_LEN) begin
      r.chars = {n.chars[31:0], ch};
      r.len   = n.len + 3'd1;
    end else begin
      r.too_long = 1'b1;
    end
    return r;
  endfunction

  function automatic sse_pkg::result_t mk_res(logic [1:0] tok, logic [1:0] tag,
                                             logic [7:0] ch, logic app, logic typ);
    sse_pkg::result_t r;
    r.token          = tok;
    r.field_tag      = tag;
    r.char_out       = ch;
    r.append_newline = app;
    r.type_given     = typ;
    return r;
  endfunction

  function automatic res_pair_t add_res(res_pair_t p, sse_pkg::result_t r);
    res_pair_t q;
    q = p;
    if (p.cnt == 2'd0) begin
      q.r0 = r;
    end else begin
      q.r1 = r;
    end
    q.cnt = p.cnt + 2'd1;
    return q;
  endfunction

  // state registers
  sse_pkg::line_mode_t line_mode, line_mode_next;
  name_t               name, name_next;
  logic [1:0]          current_field, current_field_next;
  logic                seen_data, seen_data_next;
  logic                seen_type, seen_type_next;
  logic                cr_held, cr_held_next;

  logic       accept;
  logic       restart;
  logic [7:0] c;
  logic       is_lf;

  // state after a held CR has been resolved as a real byte
  sse_pkg::line_mode_t pm;
  name_t               pn;
  logic                p_crbyte;
  logic                pst;
  logic                hit_event;
  logic                hit_data;
  logic                hit_id;

  res_pair_t pair;

  assign ingress.ready = !full;
  assign accept        = ingress.valid && ingress.ready;
  assign restart       = ingress.kind;
  assign c             = ingress.char_in;
  assign is_lf         = (c == sse_pkg::CH_LF);

  always_comb begin
    pm       = line_mode;
    pn       = name;
    p_crbyte = 1'b0;
    pst      = seen_type;
    if (cr_held && !is_lf) begin
      if (line_mode == sse_pkg::MODE_START || line_mode == sse_pkg::MODE_NAME) begin
        pn = push_name(name, sse_pkg::CH_CR);
        pm = sse_pkg::MODE_NAME;
      end else if (line_mode == sse_pkg::MODE_VALUE) begin
        p_crbyte = 1'b1;
        if (current_field == sse_pkg::FIELD_EVENT) pst = 1'b1;
      end
    end
    hit_event = !pn.too_long && pn.len == sse_pkg::LEN_EVENT && pn.chars == sse_pkg::PACK_EVENT;
    hit_data  = !pn.too_long && pn.len == sse_pkg::LEN_DATA && pn.chars == sse_pkg::PACK_DATA;
    hit_id    = !pn.too_long && pn.len == sse_pkg::LEN_ID && pn.chars == sse_pkg::PACK_ID;
  end

  // next state
  always_comb begin
    line_mode_next     = line_mode;
    name_next          = name;
    current_field_next = current_field;
    seen_data_next     = seen_data;
    seen_type_next     = seen_type;
    cr_held_next       = cr_held;
    if (restart) begin
      line_mode_next     = sse_pkg::MODE_START;
      name_next          = '0;
      current_field_next = sse_pkg::FIELD_EVENT;
      seen_data_next     = 1'b0;
      seen_type_next     = 1'b0;
      cr_held_next       = 1'b0;
    end else if (is_lf) begin
      cr_held_next   = 1'b0;
      line_mode_next = sse_pkg::MODE_START;
      name_next      = '0;
      if (line_mode == sse_pkg::MODE_START) begin
        seen_data_next     = 1'b0;
        seen_type_next     = 1'b0;
        current_field_next = sse_pkg::FIELD_EVENT;
      end
    end else begin
      cr_held_next   = 1'b0;
      line_mode_next = pm;
      name_next      = pn;
      seen_type_next = pst;
      unique case (pm)
        sse_pkg::MODE_START: begin
          if (c == sse_pkg::CH_CR) begin
            cr_held_next = 1'b1;
          end else if (c == sse_pkg::CH_COLON) begin
            line_mode_next = sse_pkg::MODE_SKIP;
          end else begin
            name_next      = push_name(pn, c);
            line_mode_next = sse_pkg::MODE_NAME;
          end
        end
        sse_pkg::MODE_NAME: begin
          if (c == sse_pkg::CH_CR) begin
            cr_held_next = 1'b1;
          end else if (c == sse_pkg::CH_COLON) begin
            name_next      = '0;
            line_mode_next = sse_pkg::MODE_VFIRST;
            if (hit_event) begin
              current_field_next = sse_pkg::FIELD_EVENT;
              seen_type_next     = 1'b0;
            end else if (hit_data) begin
              current_field_next = sse_pkg::FIELD_DATA;
              seen_data_next     = 1'b1;
            end else if (hit_id) begin
              current_field_next = sse_pkg::FIELD_ID;
            end else begin
              line_mode_next = sse_pkg::MODE_SKIP;
            end
          end else begin
            name_next = push_name(pn, c);
          end
        end
        sse_pkg::MODE_VFIRST: begin
          line_mode_next = sse_pkg::MODE_VALUE;
          if (c == sse_pkg::CH_CR) begin
            cr_held_next = 1'b1;
          end else if (c != sse_pkg::CH_SPACE && current_field == sse_pkg::FIELD_EVENT) begin
            seen_type_next = 1'b1;
          end
        end
        sse_pkg::MODE_VALUE: begin
          if (c == sse_pkg::CH_CR) begin
            cr_held_next = 1'b1;
          end else if (current_field == sse_pkg::FIELD_EVENT) begin
            seen_type_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tokens
  always_comb begin
    pair = '0;
    if (restart) begin
      pair = add_res(pair, mk_res(sse_pkg::TOK_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0));
    end else if (is_lf) begin
      if (line_mode == sse_pkg::MODE_START) begin
        if (seen_data) begin
          pair = add_res(pair, mk_res(sse_pkg::TOK_DISPATCH, 2'd0, 8'd0, 1'b0, seen_type));
        end else begin
          pair = add_res(pair, mk_res(sse_pkg::TOK_CLEAR, 2'd0, 8'd0, 1'b0, 1'b0));
        end
      end
    end else begin
      if (p_crbyte) begin
        pair = add_res(pair, mk_res(sse_pkg::TOK_BYTE, current_field, sse_pkg::CH_CR,
                                    1'b0, 1'b0));
      end
      unique case (pm)
        sse_pkg::MODE_NAME: begin
          if (c == sse_pkg::CH_COLON) begin
            if (hit_event) begin
              pair = add_res(pair, mk_res(sse_pkg::TOK_BEGIN, sse_pkg::FIELD_EVENT, 8'd0,
                                          1'b0, 1'b0));
            end else if (hit_data) begin
              pair = add_res(pair, mk_res(sse_pkg::TOK_BEGIN, sse_pkg::FIELD_DATA, 8'd0,
                                          seen_data, 1'b0));
            end else if (hit_id) begin
              pair = add_res(pair, mk_res(sse_pkg::TOK_BEGIN, sse_pkg::FIELD_ID, 8'd0,
                                          1'b0, 1'b0));
            end
          end
        end
        sse_pkg::MODE_VFIRST: begin
          if (c != sse_pkg::CH_CR && c != sse_pkg::CH_SPACE) begin
            pair = add_res(pair, mk_res(sse_pkg::TOK_BYTE, current_field, c, 1'b0, 1'b0));
          end
        end
        sse_pkg::MODE_VALUE: begin
          if (c != sse_pkg::CH_CR) begin
            pair = add_res(pair, mk_res(sse_pkg::TOK_BYTE, current_field, c, 1'b0, 1'b0));
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push          = accept && (pair.cnt != 2'd0);
  assign push_entry.two = (pair.cnt == 2'd2);
  assign push_entry.r0  = pair.r0;
  assign push_entry.r1  = pair.r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode     <= sse_pkg::MODE_START;
      name          <= '0;
      current_field <= sse_pkg::FIELD_EVENT;
      seen_data     <= 1'b0;
      seen_type     <= 1'b0;
      cr_held       <= 1'b0;
    end else if (accept) begin
      line_mode     <= line_mode_next;
      name          <= name_next;
      current_field <= current_field_next;
      seen_data     <= seen_data_next;
      seen_type     <= seen_type_next;
      cr_held       <= cr_held_next;
    end
  end

endmodule

// ----- rtl/core/sse_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_queue
// Small register FIFO of token groups between parser and output stage.
// ---------------------------------------------------------------------------
module sse_queue #(
  parameter int Depth = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sse_pkg::entry_t din,
  output logic            full,
  input  logic            pop,
  output sse_pkg::entry_t dout,
  output logic            empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sse_pkg::entry_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/sse_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_back
// Output stage: holds one token group and sends its tokens one per cycle while egress is ready.
// ---------------------------------------------------------------------------
module sse_back (
  input  logic            clk,
  input  logic            rst,
  input  sse_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  sse_out_if.source       egress
);

  logic             held;
  logic             phase;
  sse_pkg::entry_t  cur;
  sse_pkg::result_t sel;
  logic             fire;
  logic             finishing;

  assign fire      = egress.valid && egress.ready;
  assign finishing = fire && (phase || !cur.two);
  // reload in the same cycle the last token leaves
  assign pop       = !empty && (!held || finishing);

  assign sel                   = phase ? cur.r1 : cur.r0;
  assign egress.valid          = held;
  assign egress.token          = sel.token;
  assign egress.field_tag      = sel.field_tag;
  assign egress.char_out       = sel.char_out;
  assign egress.append_newline = sel.append_newline;
  assign egress.type_given     = sel.type_given;
  assign egress.last_of_run    = phase || !cur.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      phase <= 1'b0;
    end else if (pop) begin
      held  <= 1'b1;
      phase <= 1'b0;
    end else if (finishing) begin
      held  <= 1'b0;
      phase <= 1'b0;
    end else if (fire) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

endmodule

// ----- rtl/core/sse_event_stream_tokenizer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_event_stream_tokenizer
// Server-sent-events line tokenizer with a decoupled parser and output stage.
// ---------------------------------------------------------------------------
// Usage:
//   ingress carries one request per transfer: kind 0 is a stream byte in
//   char_in, kind 1 is a restart that drops the partial line and event and
//   yields one clear token. egress carries tokens (value begin, value byte,
//   dispatch, clear); last_of_run marks the final token of a request.
//   A request yields zero, one or two tokens.
// Timing:
//   The parser takes one request per cycle while the queue is not full. Its tokens
//   enter a queue of QueueDepth groups; the first token of a request reaches egress
//   through the queue and then the output stage's holding register. Output rate is one
//   token per cycle while egress is ready; the two tokens of a request leave in order.
// Reset:
//   rst clears the line state to line start and empties the queue.
// Stall:
//   When egress is held off the queue fills; ingress.ready drops only once
//   the queue is full, and tokens are never lost or reordered.
// ---------------------------------------------------------------------------
`include "sse_event_stream_tokenizer_defines.svh"

module sse_event_stream_tokenizer #(
  parameter int QueueDepth = 4
) (
  input  logic      clk,
  input  logic      rst,
  sse_in_if.sink    ingress,
  sse_out_if.source egress
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  sse_pkg::entry_t q_din;
  sse_pkg::entry_t q_dout;

  sse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ingress    (ingress),
    .full       (q_full),
    .push       (q_push),
    .push_entry (q_din)
  );

  sse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  sse_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_dout),
    .empty  (q_empty),
    .pop    (q_pop),
    .egress (egress)
  );

  `SSE_ASSERT_IMP(a_no_overflow, q_full, !q_push, "token queue written while full")
  `SSE_ASSERT_NXT(a_pair_follows, egress.valid && egress.ready && !egress.last_of_run, egress.valid, "second token of a request missing")
  `SSE_ASSERT_IMP(a_end_token_last, egress.valid && (egress.token == sse_pkg::TOK_DISPATCH || egress.token == sse_pkg::TOK_CLEAR), egress.last_of_run, "dispatch or clear not final token")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for sse_event_stream_tokenizer. A scoreboard class
// predicts the tokens of every accepted request and checks each egress token
// in order. Stimulus is a short directed run, then random event streams with
// bursty ingress, a stalling egress, one long egress hold-off and full drains.
// ---------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [1:0] token;
    logic [1:0] field_tag;
    logic [7:0] char_out;
    logic       append_newline;
    logic       type_given;
    logic       last_of_run;
  } token_t;

  class token_scoreboard;
    sse_pkg::line_mode_t mode;
    logic [39:0] name_buf;
    logic [2:0]  name_len;
    logic        name_long;
    logic [1:0]  field;
    logic        seen_data;
    logic        seen_type;
    logic        cr_held;
    token_t      expected_tokens[$];
    int          errors, requests, restarts, tokens, dispatches, clears, doubles;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      mode = sse_pkg::MODE_START;
      clear_name();
      field = sse_pkg::FIELD_EVENT;
      seen_data = 1'b0;
      seen_type = 1'b0;
      cr_held = 1'b0;
    endfunction

    function void clear_name();
      name_buf = '0;
      name_len = '0;
      name_long = 1'b0;
    endfunction

    function void push_name(logic [7:0] c);
      if (name_len < sse_pkg::NAME_MAX_LEN) begin
        name_buf = {name_buf[31:0], c};
        name_len = name_len + 3'd1;
      end else begin
        name_long = 1'b1;
      end
    endfunction

    function void emit(logic [1:0] tok, logic [1:0] tag, logic [7:0] ch, logic app,
                       logic typ);
      token_t t;
      t.token = tok;
      t.field_tag = tag;
      t.char_out = ch;
      t.append_newline = app;
      t.type_given = typ;
      t.last_of_run = 1'b0;
      expected_tokens = {expected_tokens, t};
      if (tok == sse_pkg::TOK_DISPATCH) dispatches++;
      if (tok == sse_pkg::TOK_CLEAR) clears++;
    endfunction

    function void value_byte(logic [7:0] c);
      emit(sse_pkg::TOK_BYTE, field, c, 1'b0, 1'b0);
      if (field == sse_pkg::FIELD_EVENT) seen_type = 1'b1;
    endfunction

    function void end_line();
      if (mode == sse_pkg::MODE_START) begin
        if (seen_data)
          emit(sse_pkg::TOK_DISPATCH, sse_pkg::FIELD_EVENT, 8'h00, 1'b0, seen_type);
        else emit(sse_pkg::TOK_CLEAR, sse_pkg::FIELD_EVENT, 8'h00, 1'b0, 1'b0);
        seen_data = 1'b0;
        seen_type = 1'b0;
        field = sse_pkg::FIELD_EVENT;
      end
      mode = sse_pkg::MODE_START;
      clear_name();
    endfunction

    // predict the tokens of one accepted request
    function void note_request(logic k, logic [7:0] c);
      int start_size;
      start_size = expected_tokens.size();
      requests++;
      if (k) begin
        restarts++;
        reset_state();
        emit(sse_pkg::TOK_CLEAR, sse_pkg::FIELD_EVENT, 8'h00, 1'b0, 1'b0);
      end else if (cr_held && c == sse_pkg::CH_LF) begin
        cr_held = 1'b0;
        end_line();
      end else begin
        // a held CR not followed by LF is a real byte
        if (cr_held) begin
          cr_held = 1'b0;
          if (mode == sse_pkg::MODE_START || mode == sse_pkg::MODE_NAME) begin
            push_name(sse_pkg::CH_CR);
            mode = sse_pkg::MODE_NAME;
          end else if (mode == sse_pkg::MODE_VALUE) begin
            value_byte(sse_pkg::CH_CR);
          end
        end
        case (mode)
          sse_pkg::MODE_START: begin
            if (c == sse_pkg::CH_LF) end_line();
            else if (c == sse_pkg::CH_CR) cr_held = 1'b1;
            else if (c == sse_pkg::CH_COLON) mode = sse_pkg::MODE_SKIP;
            else begin
              push_name(c);
              mode = sse_pkg::MODE_NAME;
            end
          end
          sse_pkg::MODE_NAME: begin
            if (c == sse_pkg::CH_LF) end_line();
            else if (c == sse_pkg::CH_CR) cr_held = 1'b1;
            else if (c == sse_pkg::CH_COLON) begin
              if (!name_long && name_len == sse_pkg::LEN_EVENT &&
                  name_buf == sse_pkg::PACK_EVENT) begin
                field = sse_pkg::FIELD_EVENT;
                seen_type = 1'b0;
                emit(sse_pkg::TOK_BEGIN, sse_pkg::FIELD_EVENT, 8'h00, 1'b0, 1'b0);
                mode = sse_pkg::MODE_VFIRST;
              end else if (!name_long && name_len == sse_pkg::LEN_DATA &&
                           name_buf == sse_pkg::PACK_DATA) begin
                field = sse_pkg::FIELD_DATA;
                emit(sse_pkg::TOK_BEGIN, sse_pkg::FIELD_DATA, 8'h00, seen_data, 1'b0);
                seen_data = 1'b1;
                mode = sse_pkg::MODE_VFIRST;
              end else if (!name_long && name_len == sse_pkg::LEN_ID &&
                           name_buf == sse_pkg::PACK_ID) begin
                field = sse_pkg::FIELD_ID;
                emit(sse_pkg::TOK_BEGIN, sse_pkg::FIELD_ID, 8'h00, 1'b0, 1'b0);
                mode = sse_pkg::MODE_VFIRST;
              end else begin
                mode = sse_pkg::MODE_SKIP;
              end
              clear_name();
            end else push_name(c);
          end
          sse_pkg::MODE_VFIRST: begin
            if (c == sse_pkg::CH_LF) end_line();
            else if (c == sse_pkg::CH_CR) begin
              mode = sse_pkg::MODE_VALUE;
              cr_held = 1'b1;
            end else if (c == sse_pkg::CH_SPACE) mode = sse_pkg::MODE_VALUE;
            else begin
              mode = sse_pkg::MODE_VALUE;
              value_byte(c);
            end
          end
          sse_pkg::MODE_VALUE: begin
            if (c == sse_pkg::CH_LF) end_line();
            else if (c == sse_pkg::CH_CR) cr_held = 1'b1;
            else value_byte(c);
          end
          default: begin
            if (c == sse_pkg::CH_LF) end_line();
          end
        endcase
      end
      if (expected_tokens.size() > start_size)
        expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
      if (expected_tokens.size() - start_size == 2) doubles++;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task cmp(string what, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("token %0d %s: got %0h, expected %0h", tokens, what, got, want));
    endtask

    task check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token %0d arrived with no request waiting", tokens));
      end else begin
        want = expected_tokens.pop_front();
        cmp("token", 8'(got.token), 8'(want.token));
        cmp("field_tag", 8'(got.field_tag), 8'(want.field_tag));
        cmp("char_out", got.char_out, want.char_out);
        cmp("append_newline", 8'(got.append_newline), 8'(want.append_newline));
        cmp("type_given", 8'(got.type_given), 8'(want.type_given));
        cmp("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
      end
      tokens++;
    endtask

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  sse_in_if  ingress_ch ();
  sse_out_if egress_ch ();

  sse_event_stream_tokenizer i_dut (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress_ch),
    .egress  (egress_ch)
  );

  token_scoreboard sb = new();
  int  items_sent;
  int  burst_left;
  bit  hold_req;
  int  hold_left;
  bit  ready_phase;
  int  run_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // request and token monitor
  always @(posedge clk) begin
    token_t got;
    if (!rst) begin
      if (ingress_ch.valid && ingress_ch.ready)
        sb.note_request(ingress_ch.kind, ingress_ch.char_in);
      if (egress_ch.valid && egress_ch.ready) begin
        got.token = egress_ch.token;
        got.field_tag = egress_ch.field_tag;
        got.char_out = egress_ch.char_out;
        got.append_newline = egress_ch.append_newline;
        got.type_given = egress_ch.type_given;
        got.last_of_run = egress_ch.last_of_run;
        sb.check_token(got);
      end
    end
  end

  // egress back-pressure: ready stretches, short stalls, calm stretches, long hold
  initial begin
    hold_left = 0;
    ready_phase = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        egress_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          ready_phase = !ready_phase;
          run_left = ready_phase ? $urandom_range(1, 40) : $urandom_range(1, 6);
          if (!ready_phase && $urandom_range(0, 3) == 0) begin
            ready_phase = 1'b1;
            run_left = $urandom_range(20, 60);
          end
        end
        egress_ch.ready <= ready_phase;
        run_left--;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task drive_item(logic k, logic [7:0] c);
    ingress_ch.valid <= 1'b1;
    ingress_ch.kind <= k;
    ingress_ch.char_in <= c;
    forever begin
      @(posedge clk);
      if (ingress_ch.ready) break;
    end
    @(negedge clk);
  endtask

  task put_byte(logic k, logic [7:0] c);
    int gap;
    int r;
    if (burst_left == 0) begin
      r = $urandom_range(0, 99);
      gap = (r < 30) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(5, 20);
      if (gap > 0) begin
        ingress_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    items_sent++;
    drive_item(k, c);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(1'b0, s[i]);
  endtask

  task send_eol();
    if ($urandom_range(0, 9) < 3) put_byte(1'b0, sse_pkg::CH_CR);
    put_byte(1'b0, sse_pkg::CH_LF);
  endtask

  // lowers the request and waits until every predicted token is out
  task drain_wait();
    ingress_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function logic [7:0] value_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h21, 8'h7E));
    else if (r < 80) return (r < 75) ? sse_pkg::CH_COLON : sse_pkg::CH_SPACE;
    else if (r < 88) return sse_pkg::CH_CR;
    else return 8'($urandom_range(0, 255));
  endfunction

  task gen_line();
    int    r;
    int    len;
    string nm;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      if (r < 75) begin
        case ($urandom_range(0, 9))
          0, 1, 2: nm = "event";
          8, 9:    nm = "id";
          default: nm = "data";
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0:       nm = "retry";
          1:       nm = "eventx";
          2:       nm = "dat";
          3:       nm = "idx";
          4:       nm = "event!";
          default: nm = "e";
        endcase
      end
      send_text(nm);
      put_byte(1'b0, sse_pkg::CH_COLON);
      if ($urandom_range(0, 9) < 7) put_byte(1'b0, sse_pkg::CH_SPACE);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      repeat (len) put_byte(1'b0, value_char());
    end else if (r < 88) begin
      put_byte(1'b0, sse_pkg::CH_COLON);
      repeat ($urandom_range(0, 5)) put_byte(1'b0, value_char());
    end else if (r < 94) begin
      repeat ($urandom_range(1, 6)) put_byte(1'b0, 8'($urandom_range(8'h61, 8'h7A)));
    end else begin
      repeat ($urandom_range(1, 4)) put_byte(1'b0, 8'($urandom_range(0, 255)));
    end
    send_eol();
  endtask

  task gen_event();
    repeat ($urandom_range(0, 4)) gen_line();
    if ($urandom_range(0, 99) < 3) put_byte(1'b1, 8'($urandom_range(0, 255)));
    else send_eol();
  endtask

  initial begin
    bit hold_done;
    bit pause_done;
    int waited;
    rst = 1'b1;
    ingress_ch.valid = 1'b0;
    ingress_ch.kind = 1'b0;
    ingress_ch.char_in = 8'h00;
    egress_ch.ready = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    burst_left = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: restart, empty event value, CR held before a byte in a value,
    // CR then LF, dispatch without type, comment, CR opening a name, clear
    put_byte(1'b1, 8'hFF);
    send_text("event:");
    put_byte(1'b0, sse_pkg::CH_LF);
    send_text("data: ");
    put_byte(1'b0, sse_pkg::CH_CR);
    put_byte(1'b0, 8'h00);
    put_byte(1'b0, sse_pkg::CH_CR);
    put_byte(1'b0, sse_pkg::CH_LF);
    put_byte(1'b0, sse_pkg::CH_LF);
    put_byte(1'b0, sse_pkg::CH_COLON);
    put_byte(1'b0, sse_pkg::CH_LF);
    put_byte(1'b0, sse_pkg::CH_CR);
    send_text("x");
    put_byte(1'b0, sse_pkg::CH_LF);
    put_byte(1'b0, sse_pkg::CH_LF);

    while (items_sent < 2025) begin
      gen_event();
      if (!hold_done && items_sent > 700) begin
        // long egress hold while requests keep coming, then a full drain
        ingress_ch.valid <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        send_text("data: ");
        repeat (30) put_byte(1'b0, 8'($urandom_range(8'h21, 8'h7E)));
        put_byte(1'b0, sse_pkg::CH_LF);
        drain_wait();
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent > 1400) begin
        drain_wait();
        pause_done = 1'b1;
      end
    end

    ingress_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (sb.pending() != 0)
        sb.report($sformatf("%0d predicted tokens never arrived", sb.pending()));
      $display("Covered %0d requests (%0d restarts), %0d tokens checked, %0d two-token requests",
               sb.requests, sb.restarts, sb.tokens, sb.doubles);
      $display("Events: %0d dispatches, %0d clears; long egress hold and two full drains done",
               sb.dispatches, sb.clears);
      if (sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
    end
  end

endmodule
